### rtl/frequency_ordered_list_core_assert.svh
// Assertion macros for the frequency ordered list core.
// Expects clk_i and rst_ni in the scope of the module that includes it.
`ifndef FREQUENCY_ORDERED_LIST_CORE_ASSERT_SVH
`define FREQUENCY_ORDERED_LIST_CORE_ASSERT_SVH

// Checked only outside reset.
`define FOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define FOL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/fol_pkg.sv
// Package for the frequency ordered list core: table size, widths, op and status codes.
// No dependencies.
`default_nettype none

package fol_pkg;

  localparam int DEPTH = 16;                 // table entries
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;          // holds 0..DEPTH
  localparam int KEY_W = 8;
  localparam int ACC_W = 15;
  localparam logic [ACC_W-1:0] ACC_MAX = '1; // saturating count limit

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ACCESS = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

endpackage

`default_nettype wire

### rtl/frequency_ordered_list_core.sv
// Frequency ordered list core: self-organizing table of byte keys with access counts.
// Depends on fol_pkg and frequency_ordered_list_core_assert.svh.
`default_nettype none

`include "frequency_ordered_list_core_assert.svh"

// A command is taken when start is high and busy is low; its one result shows on
// the result ports, flagged by done_o for exactly one cycle, and cannot be held off.
// Append, read and the unused op finish in the accept cycle: done_o rises on the
// next cycle and busy never rises, so a new command may follow back to back.
// In an access the walk visits each of the used entries once, and every matching
// entry then scans from the head up to its new place, one entry per cycle, before
// done_o rises. The key/count table has a single read port and one count compare
// unit, and that shared path sets the cost of an access.
// Moving a matched entry forward shifts the entries between its old and new place
// in the same cycle as the insert. No clearing pass is needed after reset: only the
// first used entries are ever read.
module frequency_ordered_list_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                op_i,
  input  wire logic [fol_pkg::KEY_W-1:0] key_i,
  input  wire logic [3:0]                position_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [4:0]                     match_count_o,
  output logic [fol_pkg::KEY_W-1:0]      entry_key_o,
  output logic [fol_pkg::ACC_W-1:0]      entry_count_o,
  output logic [3:0]                     entry_position_o
);

  import fol_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SEARCH
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  used_q;     // valid entries
  logic [IDX_W-1:0]  i_q;        // walk position
  logic [IDX_W-1:0]  j_q;        // search position
  logic [CNT_W-1:0]  matches_q;
  logic [KEY_W-1:0]  key_q;      // key being looked up
  logic [ACC_W-1:0]  cnt_q;      // updated count of the latest match
  logic [IDX_W-1:0]  last_pos_q; // where the latest match landed

  // Table storage, no reset: entries at or past used_q are never read.
  logic [KEY_W-1:0]  keys_q   [DEPTH];
  logic [ACC_W-1:0]  counts_q [DEPTH];

  logic [IDX_W-1:0]  rd_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [ACC_W-1:0]  rd_cnt;
  logic [ACC_W-1:0]  cnt_inc;
  logic              accept;
  logic              full;
  logic              last_walk;
  logic              found_slot;
  logic              do_append;
  logic              do_move;
  op_e               op;

  assign op     = op_e'(op_i);
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (used_q == CNT_W'(DEPTH));

  // Single read port: read position when idle, walk or search pointer otherwise.
  always_comb begin
    unique case (state_q)
      S_WALK:   rd_idx = i_q;
      S_SEARCH: rd_idx = j_q;
      S_IDLE:   rd_idx = IDX_W'(position_i);
      default:  rd_idx = IDX_W'(position_i);
    endcase
  end

  assign rd_key  = keys_q[rd_idx];
  assign rd_cnt  = counts_q[rd_idx];
  assign cnt_inc = (rd_cnt == ACC_MAX) ? ACC_MAX : rd_cnt + ACC_W'(1);

  // Walk ends after the entry just before used_q.
  assign last_walk  = ((CNT_W'(i_q) + CNT_W'(1)) == used_q);
  // First entry ahead with a lower count, or the match's own slot.
  assign found_slot = (j_q == i_q) || (rd_cnt < cnt_q);

  assign do_append = accept && (op == OP_APPEND) && !full;
  assign do_move   = (state_q == S_SEARCH) && found_slot;

  // Table writes: append at the tail, or insert the match at j_q and push
  // entries j_q..i_q-1 one place toward the tail.
  always_ff @(posedge clk_i) begin
    if (do_append) begin
      keys_q[used_q[IDX_W-1:0]]   <= key_i;
      counts_q[used_q[IDX_W-1:0]] <= '0;
    end else if (do_move) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (k == int'(j_q)) begin
          keys_q[k]   <= key_q;
          counts_q[k] <= cnt_q;
        end else if ((k > int'(j_q)) && (k <= int'(i_q))) begin
          keys_q[k]   <= keys_q[IDX_W'(k - 1)];
          counts_q[k] <= counts_q[IDX_W'(k - 1)];
        end
      end
    end
  end

  // Sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      used_q           <= '0;
      i_q              <= '0;
      j_q              <= '0;
      matches_q        <= '0;
      key_q            <= '0;
      cnt_q            <= '0;
      last_pos_q       <= '0;
      done_o           <= 1'b0;
      status_o         <= ST_OK;
      match_count_o    <= '0;
      entry_key_o      <= '0;
      entry_count_o    <= '0;
      entry_position_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_o         <= ST_OK;
            match_count_o    <= '0;
            entry_key_o      <= '0;
            entry_count_o    <= '0;
            entry_position_o <= '0;
            case (op)
              OP_APPEND: begin
                done_o <= 1'b1;
                if (full) begin
                  status_o <= ST_FULL;
                end else begin
                  entry_key_o      <= key_i;
                  entry_position_o <= 4'(used_q);
                  used_q           <= used_q + CNT_W'(1);
                end
              end
              OP_ACCESS: begin
                if (used_q == '0) begin
                  done_o   <= 1'b1;
                  status_o <= ST_NOTFOUND;
                end else begin
                  key_q     <= key_i;
                  i_q       <= '0;
                  matches_q <= '0;
                  state_q   <= S_WALK;
                end
              end
              OP_READ: begin
                done_o <= 1'b1;
                if (int'(position_i) >= int'(used_q)) begin
                  status_o <= ST_RANGE;
                end else begin
                  entry_key_o      <= rd_key;
                  entry_count_o    <= rd_cnt;
                  entry_position_o <= position_i;
                end
              end
              default: begin
                done_o <= 1'b1;
              end
            endcase
          end
        end

        S_WALK: begin
          if (rd_key == key_q) begin
            matches_q <= matches_q + CNT_W'(1);
            cnt_q     <= cnt_inc;
            j_q       <= '0;
            state_q   <= S_SEARCH;
          end else if (last_walk) begin
            done_o           <= 1'b1;
            state_q          <= S_IDLE;
            entry_position_o <= '0;
            if (matches_q == '0) begin
              status_o      <= ST_NOTFOUND;
              match_count_o <= '0;
              entry_key_o   <= '0;
              entry_count_o <= '0;
            end else begin
              status_o         <= ST_OK;
              match_count_o    <= 5'(matches_q);
              entry_key_o      <= key_q;
              entry_count_o    <= cnt_q;
              entry_position_o <= 4'(last_pos_q);
            end
          end else begin
            i_q <= i_q + IDX_W'(1);
          end
        end

        S_SEARCH: begin
          if (found_slot) begin
            last_pos_q <= j_q;
            if (last_walk) begin
              // A match was just placed, so the result is always ok.
              done_o           <= 1'b1;
              state_q          <= S_IDLE;
              status_o         <= ST_OK;
              match_count_o    <= 5'(matches_q);
              entry_key_o      <= key_q;
              entry_count_o    <= cnt_q;
              entry_position_o <= 4'(j_q);
            end else begin
              i_q     <= i_q + IDX_W'(1);
              state_q <= S_WALK;
            end
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  `FOL_ASSERT(a_no_done_while_busy, busy |-> !done_o, "result strobe while busy")
  `FOL_ASSERT(a_accept_progress, (start && !busy) |=> (done_o || busy), "transaction dropped")
  `FOL_ASSERT(a_used_bound, used_q <= CNT_W'(DEPTH), "entry count above table size")
  `FOL_ASSERT(a_search_bound, (state_q == S_SEARCH) |-> (j_q <= i_q), "search passed match")

endmodule

`default_nettype wire
